// ----- rtl/tsbs_pkg.sv -----
// Shared types, command codes and the byte sequencing function of the scanline streamer.
package tsbs_pkg;

	localparam logic [7:0]  CMD_COLUMN_SET = 8'h2A;
	localparam logic [7:0]  CMD_ROW_SET    = 8'h2B;
	localparam logic [7:0]  CMD_MEM_WRITE  = 8'h2C;
	localparam logic [7:0]  PARAM_ZERO     = 8'h00;
	localparam logic [15:0] GREEN_MASK     = 16'h07E0;

	localparam int unsigned HEADER_BYTES = 11;
	localparam int unsigned IDX_W        = $clog2(HEADER_BYTES);

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PANEL_WIDTH   = 3'd0,
		REG_PANEL_HEIGHT  = 3'd1,
		REG_COLUMN_OFFSET = 3'd2,
		REG_ROW_OFFSET    = 3'd3,
		REG_SWAP_RED_BLUE = 3'd4
	} reg_idx_t;

	typedef enum logic {
		JOB_HEADER = 1'b0,
		JOB_PIXEL  = 1'b1
	} job_kind_t;

	// header: a = column start, b = column end, row = row address
	// pixel : a = high byte, b = low byte, done = last pixel of the span
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] row;
		logic       done;
	} job_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
		logic       line_done;
	} beat_t;

	typedef struct packed {
		logic       push;
		job_t       job;
	} q_wr_t;

	typedef struct packed {
		logic       valid;
		job_t       job;
	} q_rd_t;

	function automatic beat_t beat_of(job_t j, idx_t i);
		beat_t b;
		b = '{out_byte: PARAM_ZERO, is_data: 1'b1, last: 1'b0, line_done: 1'b0};
		if (j.kind == JOB_PIXEL) begin
			if (i[0] == 1'b0) begin
				b.out_byte = j.a;
			end else begin
				b.out_byte  = j.b;
				b.last      = 1'b1;
				b.line_done = j.done;
			end
		end else begin
			case (i)
				idx_t'(0): begin
					b.out_byte = CMD_COLUMN_SET;
					b.is_data  = 1'b0;
				end
				idx_t'(2): b.out_byte = j.a;
				idx_t'(4): b.out_byte = j.b;
				idx_t'(5): begin
					b.out_byte = CMD_ROW_SET;
					b.is_data  = 1'b0;
				end
				idx_t'(7), idx_t'(9): b.out_byte = j.row;
				idx_t'(HEADER_BYTES - 1): begin
					b.out_byte = CMD_MEM_WRITE;
					b.is_data  = 1'b0;
					b.last     = 1'b1;
				end
				default: b.out_byte = PARAM_ZERO;
			endcase
		end
		return b;
	endfunction

endpackage

// ----- rtl/tsbs_if.sv -----
// Channel interfaces: scanline items in, panel bytes out, register writes.
interface tsbs_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [15:0] line_index;
	logic signed [15:0] span_start;
	logic signed [15:0] span_end;
	logic        [15:0] pixel_color;

	modport source (output valid, mode, line_index, span_start, span_end, pixel_color,
		input ready);
	modport sink (input valid, mode, line_index, span_start, span_end, pixel_color,
		output ready);
endinterface

interface tsbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;
	logic       line_done;

	modport source (output valid, out_byte, is_data, last, line_done, input ready);
	modport sink (input valid, out_byte, is_data, last, line_done, output ready);
endinterface

interface tsbs_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tft_scanline_byte_streamer_top.sv -----
// Top level of the TFT scanline byte streamer.
//
//  channel    dir  handshake       carries
//  pix_in     in   valid / ready   mode, line_index, span_start, span_end, pixel_color
//  byte_out   out  valid / ready   out_byte, is_data, last, line_done
//  cfg        in   valid / ready   index, data (register write, always ready)
//
// One byte leaves per cycle while byte_out is ready: a valid header is 11 bytes,
// a pixel 2; the byte sequencer and its output register set this rate.
// Items are accepted while the 4-job queue has room; dropped items are accepted but not queued.
// A stalled byte_out holds its beat; the front keeps accepting until the queue fills.
// arst_n clears span state, queue and output valid, and loads register reset values.
module tft_scanline_byte_streamer_top (
	input  logic        clk,
	input  logic        arst_n,
	tsbs_in_if.sink     pix_in,
	tsbs_out_if.source  byte_out,
	tsbs_cfg_if.sink    cfg
);
	import tsbs_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	tsbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.cfg    (cfg),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	tsbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.q_rd   (q_rd)
	);

	tsbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (q_pop),
		.byte_out (byte_out)
	);

endmodule

// ----- rtl/tsbs_front.sv -----
// Front end: register file, header window checks, span counter and job build.
module tsbs_front (
	input  logic           clk,
	input  logic           arst_n,
	tsbs_in_if.sink        pix_in,
	tsbs_cfg_if.sink       cfg,
	input  logic           q_full,
	output tsbs_pkg::q_wr_t q_wr
);
	import tsbs_pkg::*;

	logic [8:0]  panel_width_q;
	logic [8:0]  panel_height_q;
	logic [7:0]  column_offset_q;
	logic [7:0]  row_offset_q;
	logic        swap_red_blue_q;
	logic [8:0]  pixels_left_q;
	logic        line_active_q;

	logic        accept;
	logic        y_ok, xs_ok, xe_ok, order_ok, hdr_ok, pix_live;
	logic [8:0]  span_len;
	logic [15:0] color;
	job_t        job;

	assign cfg.ready    = 1'b1;
	assign pix_in.ready = !q_full;
	assign accept       = pix_in.valid && pix_in.ready;

	always_comb begin
		y_ok     = !pix_in.line_index[15]
			&& (pix_in.line_index[14:0] < 15'(panel_height_q));
		xs_ok    = !pix_in.span_start[15]
			&& (pix_in.span_start[14:0] < 15'(panel_width_q));
		xe_ok    = !pix_in.span_end[15]
			&& (pix_in.span_end[14:0] < 15'(panel_width_q));
		order_ok = pix_in.span_start <= pix_in.span_end;
		hdr_ok   = y_ok && xs_ok && xe_ok && order_ok;
		// both ends are below the width here, so nine bits hold the count
		span_len = pix_in.span_end[8:0] - pix_in.span_start[8:0] + 9'd1;
		pix_live = line_active_q && (pixels_left_q != 9'd0);

		color = pix_in.pixel_color;
		if (swap_red_blue_q)
			color = {pix_in.pixel_color[4:0], 6'b0, pix_in.pixel_color[15:11]}
				| (pix_in.pixel_color & GREEN_MASK);

		job.kind = (pix_in.mode == 1'b0) ? JOB_HEADER : JOB_PIXEL;
		job.done = (pixels_left_q == 9'd1);
		job.row  = pix_in.line_index[7:0] + row_offset_q;
		if (pix_in.mode == 1'b0) begin
			job.a = pix_in.span_start[7:0] + column_offset_q;
			job.b = pix_in.span_end[7:0] + column_offset_q;
		end else begin
			job.a = color[15:8];
			job.b = color[7:0];
		end

		q_wr.job  = job;
		q_wr.push = accept && ((pix_in.mode == 1'b0) ? hdr_ok : pix_live);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q   <= 9'd128;
			panel_height_q  <= 9'd160;
			column_offset_q <= '0;
			row_offset_q    <= '0;
			swap_red_blue_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PANEL_WIDTH:   panel_width_q   <= cfg.data;
				REG_PANEL_HEIGHT:  panel_height_q  <= cfg.data;
				REG_COLUMN_OFFSET: column_offset_q <= cfg.data[7:0];
				REG_ROW_OFFSET:    row_offset_q    <= cfg.data[7:0];
				REG_SWAP_RED_BLUE: swap_red_blue_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
			line_active_q <= 1'b0;
		end else if (accept) begin
			if (pix_in.mode == 1'b0) begin
				// any header abandons the running span
				line_active_q <= hdr_ok;
				pixels_left_q <= hdr_ok ? span_len : 9'd0;
			end else if (!pix_live) begin
				line_active_q <= 1'b0;
				pixels_left_q <= '0;
			end else begin
				pixels_left_q <= pixels_left_q - 9'd1;
				if (pixels_left_q == 9'd1)
					line_active_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/tsbs_queue.sv -----
// Small job FIFO between the front end and the byte sequencer.
module tsbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  tsbs_pkg::q_wr_t q_wr,
	output logic            full,
	input  logic            pop,
	output tsbs_pkg::q_rd_t q_rd
);
	import tsbs_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.job   = mem_q[rd_ptr_q];
	assign do_pop     = pop && q_rd.valid;

	always_ff @(posedge clk) begin
		if (q_wr.push)
			mem_q[wr_ptr_q] <= q_wr.job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (q_wr.push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (!q_wr.push && do_pop)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// ----- rtl/tsbs_back.sv -----
// Back end: walks each job byte by byte into the output register.
module tsbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tsbs_pkg::q_rd_t q_rd,
	output logic            pop,
	tsbs_out_if.source      byte_out
);
	import tsbs_pkg::*;

	job_t  job_q;
	idx_t  idx_q;
	logic  busy_q;
	logic  out_valid_q;
	beat_t out_beat_q;
	beat_t beat;
	logic  advance;

	always_comb begin
		beat    = beat_of(job_q, idx_q);
		advance = busy_q && (!out_valid_q || byte_out.ready);
		// next job is taken in the cycle the current one moves its final beat to the output register
		pop     = q_rd.valid && (!busy_q || (advance && beat.last));
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= q_rd.job;
		if (advance)
			out_beat_q <= beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && beat.last) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + idx_t'(1);
			end

			if (advance)
				out_valid_q <= 1'b1;
			else if (byte_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign byte_out.valid     = out_valid_q;
	assign byte_out.out_byte  = out_beat_q.out_byte;
	assign byte_out.is_data   = out_beat_q.is_data;
	assign byte_out.last      = out_beat_q.last;
	assign byte_out.line_done = out_beat_q.line_done;

endmodule

// ----- rtl/tsbs_checker.sv -----
// Port-level checks of the output byte stream, bound to the top level.
module tsbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_data,
	input logic       last,
	input logic       line_done
);
	import tsbs_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output beat changed while stalled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last && is_data)
		else $error("line_done on a beat that is not a final pixel byte");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> out_byte == CMD_COLUMN_SET
			|| out_byte == CMD_ROW_SET || out_byte == CMD_MEM_WRITE)
		else $error("unknown command byte");

	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> last == (out_byte == CMD_MEM_WRITE))
		else $error("header sequence closed on the wrong command");

endmodule

bind tft_scanline_byte_streamer_top tsbs_checker u_tsbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (byte_out.valid),
	.out_ready (byte_out.ready),
	.out_byte  (byte_out.out_byte),
	.is_data   (byte_out.is_data),
	.last      (byte_out.last),
	.line_done (byte_out.line_done)
);
